/* hw/rtl/dwc_pkg.sv */
// Shared codes, constants and coefficient tables for the dynamic window check.
`default_nettype none

package dwc_pkg;

  // Detector region of one eta value.
  typedef logic [1:0] region_t;
  localparam region_t REG_BARREL  = 2'd0;
  localparam region_t REG_POS_END = 2'd1;
  localparam region_t REG_NEG_END = 2'd2;

  // Pieces of the upper eta bound, in rising |eta| order.
  typedef logic [2:0] up_piece_t;
  localparam up_piece_t UP_FLAT_LO = 3'd0;
  localparam up_piece_t UP_QUAD    = 3'd1;
  localparam up_piece_t UP_MID     = 3'd2;
  localparam up_piece_t UP_LIN     = 3'd3;
  localparam up_piece_t UP_FLAT_HI = 3'd4;

  // Pieces of the lower eta bound.
  typedef logic [1:0] dn_piece_t;
  localparam dn_piece_t DN_FLAT_LO = 2'd0;
  localparam dn_piece_t DN_LIN     = 2'd1;
  localparam dn_piece_t DN_FLAT_HI = 2'd2;

  // Pieces of the phi bound.
  typedef logic [1:0] ph_piece_t;
  localparam ph_piece_t PH_FLAT_LO = 2'd0;
  localparam ph_piece_t PH_LIN     = 2'd1;
  localparam ph_piece_t PH_FLAT_HI = 2'd2;

  // Pi and two pi with 30 fraction bits.
  localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

  // Eta bounds are held in units of 1e-7.
  localparam logic signed [24:0] ETA_SCALE = 25'sd10000000;

  // Constant term of the upper eta bound, units of 1e-7.
  function automatic logic signed [23:0] up_c0(up_piece_t p);
    logic signed [23:0] c;
    unique case (p)
      UP_FLAT_LO: c = 24'sd750000;
      UP_QUAD:    c = 24'sd758929;
      UP_MID:     c = 24'sd2000000;
      UP_LIN:     c = 24'sd6250000;
      default:    c = 24'sd1500000;
    endcase
    return c;
  endfunction

  // Linear term of the upper eta bound.
  function automatic logic signed [22:0] up_c1(up_piece_t p);
    logic signed [22:0] c;
    unique case (p)
      UP_QUAD: c = -23'sd178571;
      UP_LIN:  c = -23'sd2500000;
      default: c = 23'sd0;
    endcase
    return c;
  endfunction

  // Quadratic term of the upper eta bound.
  function automatic logic [19:0] up_c2(up_piece_t p);
    logic [19:0] c;
    unique case (p)
      UP_QUAD: c = 20'd892857;
      default: c = 20'd0;
    endcase
    return c;
  endfunction

  // Constant term of the lower eta bound.
  function automatic logic signed [23:0] dn_c0(dn_piece_t p);
    logic signed [23:0] c;
    unique case (p)
      DN_FLAT_LO: c = -24'sd750000;
      DN_LIN:     c = 24'sd3187500;
      default:    c = -24'sd1500000;
    endcase
    return c;
  endfunction

  // Linear term of the lower eta bound.
  function automatic logic signed [22:0] dn_c1(dn_piece_t p);
    logic signed [22:0] c;
    unique case (p)
      DN_LIN:  c = -23'sd1875000;
      default: c = 23'sd0;
    endcase
    return c;
  endfunction

  // Constant term of the phi bound, units of 1e-3 rad.
  function automatic logic signed [11:0] ph_c0(ph_piece_t p);
    logic signed [11:0] c;
    unique case (p)
      PH_FLAT_LO: c = 12'sd600;
      PH_LIN:     c = 12'sd1075;
      default:    c = 12'sd400;
    endcase
    return c;
  endfunction

  // Linear term of the phi bound.
  function automatic logic signed [8:0] ph_c1(ph_piece_t p);
    logic signed [8:0] c;
    unique case (p)
      PH_LIN:  c = -9'sd250;
      default: c = 9'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dynamic_window_check_top.sv */
// Top level of the dynamic window check: a five stage pipeline.
`default_nettype none

// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_ref_eta, in_ref_phi, in_seed_eta, in_seed_phi
// out_     output     out_valid/out_stall out_in_window
//
// One word enters per clock unless in_stall is high; the pipeline depth
// is set by the chain of coefficient products, bound sums and compares.
// Each stage holds its own valid bit and moves on when the stage after it is
// empty or moving, so bubbles close up while the output is stalled and a
// stall never drops or repeats a word.
// Reset (rst_n low, synchronous) clears only the valid bits.

module dynamic_window_check_top #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [14:0] in_ref_eta,
  input  wire logic signed [14:0] in_ref_phi,
  input  wire logic signed [14:0] in_seed_eta,
  input  wire logic signed [14:0] in_seed_phi,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_in_window
);

  // Working width of the bound arithmetic. The eta bounds carry a scale of
  // 1e7 * 2^(2*FRAC_BITS); the phi compare carries 1000 * 2^30.
  localparam int W = (2 * FRAC_BITS + 28 > FRAC_BITS + 48) ?
                     2 * FRAC_BITS + 28 : FRAC_BITS + 48;
  localparam int PH_SH = 30 - FRAC_BITS;

  // Thresholds on 10 * |eta|, so that tenths compare exactly.
  localparam logic [W-1:0] TH_01 = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] TH_13 = W'(13) << FRAC_BITS;
  localparam logic [W-1:0] TH_17 = W'(17) << FRAC_BITS;
  localparam logic [W-1:0] TH_19 = W'(19) << FRAC_BITS;
  localparam logic [W-1:0] TH_21 = W'(21) << FRAC_BITS;
  localparam logic [W-1:0] TH_25 = W'(25) << FRAC_BITS;
  localparam logic [W-1:0] TH_27 = W'(27) << FRAC_BITS;
  // Barrel edge on 1000 * |eta|.
  localparam logic [W-1:0] BARREL_LIM = W'(1479) << FRAC_BITS;

  localparam logic signed [W-1:0] PI_W     = W'(dwc_pkg::PI_Q30);
  localparam logic signed [W-1:0] TWO_PI_W = W'(dwc_pkg::TWO_PI_Q30);
  localparam logic signed [W-1:0] MILLI    = W'(1000);

  // Stage enables: a stage loads when its successor is empty or loading.
  logic en1, en2, en3, en4, en5;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  assign en5 = !out_valid_r || !out_stall;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Stage 1: regions, |seed eta|, eta offset, phi difference, piece choice.
  // ---------------------------------------------------------------------
  logic [14:0]         ref_abs, seed_abs;
  logic [W-1:0]        seed_abs_w, seed_a10;
  dwc_pkg::region_t    ref_reg, seed_reg;
  logic signed [15:0]  eta_diff, eta_off, phi_diff;
  dwc_pkg::up_piece_t  up_p;
  dwc_pkg::dn_piece_t  dn_p;
  dwc_pkg::ph_piece_t  ph_p;

  always_comb begin
    ref_abs    = in_ref_eta[14] ? 15'(-in_ref_eta) : 15'(in_ref_eta);
    seed_abs   = in_seed_eta[14] ? 15'(-in_seed_eta) : 15'(in_seed_eta);
    seed_abs_w = W'(seed_abs);
    seed_a10   = (seed_abs_w << 3) + (seed_abs_w << 1);

    if (W'(ref_abs) * W'(1000) > BARREL_LIM) begin
      ref_reg = in_ref_eta[14] ? dwc_pkg::REG_NEG_END : dwc_pkg::REG_POS_END;
    end else begin
      ref_reg = dwc_pkg::REG_BARREL;
    end
    if (seed_abs_w * W'(1000) > BARREL_LIM) begin
      seed_reg = in_seed_eta[14] ? dwc_pkg::REG_NEG_END : dwc_pkg::REG_POS_END;
    end else begin
      seed_reg = dwc_pkg::REG_BARREL;
    end

    // The offset is mirrored for a negative reference so that it points
    // away from the beam line on both sides.
    eta_diff = 16'(in_seed_eta) - 16'(in_ref_eta);
    eta_off  = in_ref_eta[14] ? -eta_diff : eta_diff;
    phi_diff = 16'(in_ref_phi) - 16'(in_seed_phi);

    priority if (seed_a10 < TH_01) up_p = dwc_pkg::UP_FLAT_LO;
    else if (seed_a10 < TH_13)     up_p = dwc_pkg::UP_QUAD;
    else if (seed_a10 < TH_17)     up_p = dwc_pkg::UP_MID;
    else if (seed_a10 < TH_19)     up_p = dwc_pkg::UP_LIN;
    else                           up_p = dwc_pkg::UP_FLAT_HI;

    priority if (seed_a10 < TH_21) dn_p = dwc_pkg::DN_FLAT_LO;
    else if (seed_a10 < TH_25)     dn_p = dwc_pkg::DN_LIN;
    else                           dn_p = dwc_pkg::DN_FLAT_HI;

    priority if (seed_a10 < TH_19) ph_p = dwc_pkg::PH_FLAT_LO;
    else if (seed_a10 < TH_27)     ph_p = dwc_pkg::PH_LIN;
    else                           ph_p = dwc_pkg::PH_FLAT_HI;
  end

  logic                s1_same_r;
  logic [14:0]         s1_a_r;
  logic signed [15:0]  s1_e_r, s1_d_r;
  dwc_pkg::up_piece_t  s1_up_r;
  dwc_pkg::dn_piece_t  s1_dn_r;
  dwc_pkg::ph_piece_t  s1_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_same_r <= (ref_reg == seed_reg);
      s1_a_r    <= seed_abs;
      s1_e_r    <= eta_off;
      s1_d_r    <= phi_diff;
      s1_up_r   <= up_p;
      s1_dn_r   <= dn_p;
      s1_ph_r   <= ph_p;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: |eta| squared, linear coefficient products, scaled offset and
  // the single phi wrap.
  // ---------------------------------------------------------------------
  logic signed [15:0]  a_s;
  logic signed [W-1:0] d30, d_wrap;

  always_comb begin
    a_s = $signed({1'b0, s1_a_r});
    d30 = W'(s1_d_r) <<< PH_SH;
    if (d30 > PI_W) begin
      d_wrap = d30 - TWO_PI_W;
    end else if (d30 < -PI_W) begin
      d_wrap = d30 + TWO_PI_W;
    end else begin
      d_wrap = d30;
    end
  end

  logic                s2_same_r;
  logic [28:0]         s2_a2_r;
  logic signed [40:0]  s2_e7_r;
  logic signed [38:0]  s2_upc1a_r, s2_dnc1a_r;
  logic signed [24:0]  s2_phc1a_r;
  logic signed [W-1:0] s2_dw_r;
  dwc_pkg::up_piece_t  s2_up_r;
  dwc_pkg::dn_piece_t  s2_dn_r;
  dwc_pkg::ph_piece_t  s2_ph_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_same_r  <= s1_same_r;
      s2_a2_r    <= 29'(s1_a_r) * 29'(s1_a_r);
      s2_e7_r    <= 41'(s1_e_r) * 41'(dwc_pkg::ETA_SCALE);
      s2_upc1a_r <= 39'(dwc_pkg::up_c1(s1_up_r)) * 39'(a_s);
      s2_dnc1a_r <= 39'(dwc_pkg::dn_c1(s1_dn_r)) * 39'(a_s);
      s2_phc1a_r <= 25'(dwc_pkg::ph_c1(s1_ph_r)) * 25'(a_s);
      s2_dw_r    <= d_wrap;
      s2_up_r    <= s1_up_r;
      s2_dn_r    <= s1_dn_r;
      s2_ph_r    <= s1_ph_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: quadratic term, offset at full scale, phi magnitude and bound.
  // ---------------------------------------------------------------------
  logic signed [W-1:0] dmag;

  assign dmag = s2_dw_r[W-1] ? -s2_dw_r : s2_dw_r;

  logic                s3_same_r;
  logic signed [W-1:0] s3_lhs_r, s3_pbound_r, s3_dm1000_r;
  logic [48:0]         s3_upq_r;
  logic signed [38:0]  s3_upc1a_r, s3_dnc1a_r;
  dwc_pkg::up_piece_t  s3_up_r;
  dwc_pkg::dn_piece_t  s3_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_same_r   <= s2_same_r;
      s3_lhs_r    <= W'(s2_e7_r) <<< FRAC_BITS;
      s3_upq_r    <= 49'(dwc_pkg::up_c2(s2_up_r)) * 49'(s2_a2_r);
      s3_upc1a_r  <= s2_upc1a_r;
      s3_dnc1a_r  <= s2_dnc1a_r;
      s3_pbound_r <= (W'(dwc_pkg::ph_c0(s2_ph_r)) <<< 30) + (W'(s2_phc1a_r) <<< PH_SH);
      s3_dm1000_r <= dmag * MILLI;
      s3_up_r     <= s2_up_r;
      s3_dn_r     <= s2_dn_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: eta bound sums and the phi compare.
  // ---------------------------------------------------------------------
  logic                s4_same_r, s4_phi_ok_r;
  logic signed [W-1:0] s4_lhs_r, s4_upb_r, s4_dnb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_same_r   <= s3_same_r;
      s4_lhs_r    <= s3_lhs_r;
      s4_upb_r    <= (W'(dwc_pkg::up_c0(s3_up_r)) <<< (2 * FRAC_BITS))
                   + (W'(s3_upc1a_r) <<< FRAC_BITS)
                   + $signed(W'(s3_upq_r));
      s4_dnb_r    <= (W'(dwc_pkg::dn_c0(s3_dn_r)) <<< (2 * FRAC_BITS))
                   + (W'(s3_dnc1a_r) <<< FRAC_BITS);
      s4_phi_ok_r <= (s3_dm1000_r <= s3_pbound_r);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: eta window compare and the output register.
  // ---------------------------------------------------------------------
  logic out_in_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en5) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_in_window_r <= s4_same_r && s4_phi_ok_r &&
                         (s4_lhs_r >= s4_dnb_r) && (s4_lhs_r <= s4_upb_r);
    end
  end

  assign out_in_window = out_in_window_r;

endmodule

`default_nettype wire

/* tb/dynamic_window_check_top_tb.sv */
// Self-checking testbench for the dynamic window check pipeline.
`timescale 1ns / 100ps

module dynamic_window_check_top_tb;

  localparam int FRAC = 12;
  // The drain gives a margin after the last expected result is checked.
  localparam int DRAIN_CYCLES = 20;
  // Longest deliberate hold-off of the result side.
  localparam int HOLD_CYCLES = 300;
  // Cycles with no word moving on either side before the run is abandoned.
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic signed [14:0] ref_eta;
    logic signed [14:0] ref_phi;
    logic signed [14:0] seed_eta;
    logic signed [14:0] seed_phi;
  } pair_t;

  // Keeps the expected window decisions in arrival order and checks each
  // result word against the oldest one.
  class window_scoreboard;
    localparam int FB = 12;
    localparam longint PHI_PI = 64'sd3373259426;
    localparam longint PHI_TWO_PI = 64'sd6746518852;
    localparam longint Q30 = 64'sd1 <<< 30;

    bit expected_hits[$];
    int failures;

    function dwc_pkg::region_t region_of_eta(longint eta);
      longint mag;
      mag = (eta < 0) ? -eta : eta;
      if (mag * 1000 > 1479 * (64'sd1 <<< FB))
        return (eta > 0) ? dwc_pkg::REG_POS_END : dwc_pkg::REG_NEG_END;
      return dwc_pkg::REG_BARREL;
    endfunction

    // True when the magnitude reaches t tenths.
    function bit reaches_tenths(longint mag, longint t);
      return mag * 10 >= t * (64'sd1 <<< FB);
    endfunction

    // Bound in units of 1e-7, scaled by 2^(2*FB).
    function longint eta_limit(longint mag, longint c0, longint c1, longint c2);
      longint s;
      s = 64'sd1 <<< FB;
      return c0 * s * s + c1 * mag * s + c2 * mag * mag;
    endfunction

    function bit window_hit(pair_t p);
      longint reta, rphi, seta, sphi, s, offs, mag, up, down, dphi, dmag, pbound;
      reta = p.ref_eta;
      rphi = p.ref_phi;
      seta = p.seed_eta;
      sphi = p.seed_phi;
      s = 64'sd1 <<< FB;
      if (region_of_eta(reta) != region_of_eta(seta)) return 1'b0;

      offs = seta - reta;
      if (reta < 0) offs = -offs;
      mag = (seta < 0) ? -seta : seta;

      if (!reaches_tenths(mag, 1)) up = eta_limit(mag, 750000, 0, 0);
      else if (!reaches_tenths(mag, 13)) up = eta_limit(mag, 758929, -178571, 892857);
      else if (!reaches_tenths(mag, 17)) up = eta_limit(mag, 2000000, 0, 0);
      else if (!reaches_tenths(mag, 19)) up = eta_limit(mag, 6250000, -2500000, 0);
      else up = eta_limit(mag, 1500000, 0, 0);

      if (!reaches_tenths(mag, 21)) down = eta_limit(mag, -750000, 0, 0);
      else if (!reaches_tenths(mag, 25)) down = eta_limit(mag, 3187500, -1875000, 0);
      else down = eta_limit(mag, -1500000, 0, 0);

      if (offs * s * 64'sd10000000 < down || offs * s * 64'sd10000000 > up) return 1'b0;

      // Phi offset with 30 fraction bits, wrapped by a single correction.
      dphi = (rphi - sphi) * (64'sd1 <<< (30 - FB));
      if (dphi > PHI_PI) dphi = dphi - PHI_TWO_PI;
      if (dphi < -PHI_PI) dphi = dphi + PHI_TWO_PI;
      dmag = (dphi < 0) ? -dphi : dphi;

      if (!reaches_tenths(mag, 19)) pbound = 600 * Q30;
      else if (!reaches_tenths(mag, 27))
        pbound = 1075 * Q30 - 250 * mag * (64'sd1 <<< (30 - FB));
      else pbound = 400 * Q30;

      return dmag * 1000 <= pbound;
    endfunction

    function void note_pair(pair_t p);
      expected_hits = {expected_hits, window_hit(p)};
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual in_window=%0b",
                 $time, got);
        failures++;
        return;
      end
      want = expected_hits.pop_front();
      if (got !== want) begin
        $display("%0t: in_window mismatch, expected %0b, actual %0b", $time, want, got);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [14:0] in_ref_eta;
  logic signed [14:0] in_ref_phi;
  logic signed [14:0] in_seed_eta;
  logic signed [14:0] in_seed_phi;
  logic out_valid;
  logic out_stall;
  logic out_in_window;

  window_scoreboard sb = new;

  // Percentages that shape the traffic of each phase. The sender's idle rate
  // is read only by the driving process; the result side's stall rate and the
  // hold-off request are read by the result process, so they change by
  // nonblocking assignment at the clock edge.
  int idle_pct;
  int stall_pct;
  logic hold_armed;
  int hold_count;
  int quiet_cycles;

  dynamic_window_check_top #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_ref_eta(in_ref_eta),
    .in_ref_phi(in_ref_phi),
    .in_seed_eta(in_seed_eta),
    .in_seed_phi(in_seed_phi),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_in_window(out_in_window)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side. While a hold-off is armed it stalls until hold_count,
  // counted here, reaches HOLD_CYCLES, so the pipeline fills and pushes back
  // on the sender. Otherwise it stalls at random at the current rate.
  always @(posedge clk) begin
    if (!hold_armed) begin
      hold_count <= 0;
    end else if (hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < stall_pct);
    end
  end

  // Every word taken on the input side gets its expectation right away, so
  // the queue always holds the words in the order the pipeline keeps them.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid && in_stall === 1'b0) begin
      sb.note_pair({in_ref_eta, in_ref_phi, in_seed_eta, in_seed_phi});
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      sb.check_result(out_in_window);
    end
  end

  // Watchdog: a long spell with no word moving on either side means the
  // block has hung.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("dynamic_window_check_top_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic int clamp15(int v);
    if (v > 16383) return 16383;
    if (v < -16384) return -16384;
    return v;
  endfunction

  // Offers one word and returns at the edge that takes it. An idle gap, when
  // drawn, comes first; valid is then raised and held with steady fields
  // until the stall is low.
  task automatic send_pair(int re, int rp, int se, int sp);
    if (idle_pct > 0 && int'($urandom_range(99)) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (int'($urandom_range(99)) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ref_eta <= 15'(re);
    in_ref_phi <= 15'(rp);
    in_seed_eta <= 15'(se);
    in_seed_phi <= 15'(sp);
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Most words are seed and reference close together in eta and phi, so the
  // decision falls on both sides of the window edges; some straddle the phi
  // wrap and the rest are raw bit patterns over the whole field range.
  function automatic pair_t random_pair();
    pair_t p;
    int pick, re, rp, se, sp, t;
    pick = int'($urandom_range(99));
    if (pick < 30) begin
      p.ref_eta = 15'($urandom);
      p.ref_phi = 15'($urandom);
      p.seed_eta = 15'($urandom);
      p.seed_phi = 15'($urandom);
      return p;
    end
    re = int'($urandom_range(32767)) - 16384;
    se = clamp15(re + int'($urandom_range(1200)) - 600);
    if (pick < 42) begin
      // Offsets near two pi that the wrap brings back into the window.
      rp = int'($urandom_range(16383, 11000));
      sp = clamp15(rp - 25736 + int'($urandom_range(6000)) - 3000);
      if ($urandom_range(1) == 1) begin
        t = rp;
        rp = sp;
        sp = t;
      end
    end else begin
      rp = int'($urandom_range(32767)) - 16384;
      sp = clamp15(rp + int'($urandom_range(6000)) - 3000);
    end
    p.ref_eta = 15'(re);
    p.ref_phi = 15'(rp);
    p.seed_eta = 15'(se);
    p.seed_phi = 15'(sp);
    return p;
  endfunction

  task automatic run_phase(int count, int idle, int stall);
    pair_t p;
    idle_pct = idle;
    stall_pct <= stall;
    repeat (count) begin
      p = random_pair();
      send_pair(p.ref_eta, p.ref_phi, p.seed_eta, p.seed_phi);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_ref_eta <= '0;
    in_ref_phi <= '0;
    in_seed_eta <= '0;
    in_seed_phi <= '0;
    out_stall <= 1'b0;
    hold_armed <= 1'b0;
    stall_pct <= 0;
    idle_pct = 0;
    quiet_cycles <= 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words, sent back to back.
    // Both positions at the origin: barrel, zero offsets.
    send_pair(0, 0, 0, 0);
    // Field extremes, all high, all low and mixed.
    send_pair(16383, 16383, 16383, 16383);
    send_pair(-16384, -16384, -16384, -16384);
    send_pair(16383, -16384, 16383, 16383);
    send_pair(-16384, 16383, -16384, -16384);
    // Region boundary: 6057 is still barrel, 6058 is already endcap.
    send_pair(6057, 0, 6058, 0);
    send_pair(6058, 0, 6058, 0);
    send_pair(-6057, 0, -6058, 0);
    send_pair(-6057, 0, -6057, 0);
    // Zero reference eta leaves the offset unflipped; a negative one flips it.
    send_pair(0, 0, 300, 0);
    send_pair(0, 0, -300, 0);
    send_pair(-100, 0, 200, 0);
    // Central eta window edges, just inside and just outside.
    send_pair(0, 0, 307, 0);
    send_pair(0, 0, 308, 0);
    send_pair(0, 0, -307, 0);
    send_pair(0, 0, -308, 0);
    // Linear piece of the upper bound, met exactly and passed by one step.
    send_pair(6190, 0, 7000, 0);
    send_pair(6189, 0, 7000, 0);
    // Phi bound in the barrel, both sides of the edge.
    send_pair(0, 2457, 0, 0);
    send_pair(0, 0, 0, 2458);
    // Phi bound in the far endcap and on the linear piece.
    send_pair(12000, 1638, 12000, 0);
    send_pair(12000, 0, 12000, 1639);
    send_pair(8000, 2403, 8000, 0);
    send_pair(8000, 2404, 8000, 0);
    // Wrap across pi in both directions; a full-scale offset stays outside.
    send_pair(0, 12868, 0, -12868);
    send_pair(0, -12868, 0, 12868);
    send_pair(0, 16383, 0, -16384);

    // Random phases with different traffic on each side.
    run_phase(100, 0, 0);
    run_phase(100, 81, 0);
    run_phase(100, 0, 81);
    run_phase(100, 31, 31);

    // Long hold-off on the result side while the sender keeps offering.
    hold_armed <= 1'b1;
    run_phase(40, 0, 0);
    hold_armed <= 1'b0;

    run_phase(40, 31, 81);
    in_valid <= 1'b0;

    while (sb.expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.expected_hits.size() == 0) begin
      $display("dynamic_window_check_top_tb: PASS");
    end else begin
      $display("dynamic_window_check_top_tb: FAIL");
    end
    $finish;
  end

endmodule
